>>> design/rhcc_pkg.sv
`timescale 1ns / 1ps

package rhcc_pkg;

   localparam int CompWidth   = 8;    // one color component
   localparam int QuotWidth   = 9;    // hue 0..359, saturation 0..256
   localparam int HueNumWidth = 17;   // hue numerator below 360 * 255
   localparam int SatNumWidth = 16;   // delta * 256
   localparam int CsrWidth    = 9;
   localparam int CsrIdxWidth = 3;

   // One slot of the restoring divider pipeline: both divisions run side by side.
   typedef struct packed {
      logic [HueNumWidth-1:0] hue_rem;
      logic [QuotWidth-1:0]   hue_quot;
      logic [CompWidth-1:0]   delta;      // hue divisor
      logic [SatNumWidth-1:0] sat_rem;
      logic [QuotWidth-1:0]   sat_quot;
      logic [CompWidth-1:0]   max_val;    // saturation divisor
   } div_stage_type;

endpackage

>>> design/rhcc_div_pipe.sv
`timescale 1ns / 1ps

// Pipelined restoring divider, one quotient bit per stage, MSB first.
// Hue: num / delta. Saturation: (delta << 8) / max. A zero divisor forces every
// quotient bit to zero; the remainder keeps the dividend, which is then zero too.
module rhcc_div_pipe (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  rhcc_pkg::div_stage_type div_in,
   output logic                   out_valid,
   output rhcc_pkg::div_stage_type div_out
);

   localparam int Stages = rhcc_pkg::QuotWidth;

   rhcc_pkg::div_stage_type stage_ff [Stages];
   rhcc_pkg::div_stage_type stage_in [Stages];
   rhcc_pkg::div_stage_type stage_src [Stages];
   logic [Stages-1:0]       valid_ff;

   for (genvar k = 0; k < Stages; k++) begin : g_stage
      localparam int Shift = Stages - 1 - k;

      logic [rhcc_pkg::HueNumWidth-1:0] hue_sub;
      logic [rhcc_pkg::SatNumWidth-1:0] sat_sub;
      logic                             hue_bit;
      logic                             sat_bit;

      if (k == 0) begin : g_first
         assign stage_src[k] = div_in;
      end else begin : g_next
         assign stage_src[k] = stage_ff[k-1];
      end

      assign hue_sub = rhcc_pkg::HueNumWidth'(stage_src[k].delta) << Shift;
      assign sat_sub = rhcc_pkg::SatNumWidth'(stage_src[k].max_val) << Shift;
      assign hue_bit = (stage_src[k].delta != '0) && (stage_src[k].hue_rem >= hue_sub);
      assign sat_bit = (stage_src[k].max_val != '0) && (stage_src[k].sat_rem >= sat_sub);

      always_comb begin
         stage_in[k]          = stage_src[k];
         stage_in[k].hue_quot = {stage_src[k].hue_quot[rhcc_pkg::QuotWidth-2:0], hue_bit};
         stage_in[k].sat_quot = {stage_src[k].sat_quot[rhcc_pkg::QuotWidth-2:0], sat_bit};
         if (hue_bit) begin
            stage_in[k].hue_rem = stage_src[k].hue_rem - hue_sub;
         end
         if (sat_bit) begin
            stage_in[k].sat_rem = stage_src[k].sat_rem - sat_sub;
         end
      end

      always_ff @(posedge clock) begin
         stage_ff[k] <= stage_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[Stages-2:0], in_valid};
      end
   end

   assign out_valid = valid_ff[Stages-1];
   assign div_out   = stage_ff[Stages-1];

endmodule

>>> design/rgb_to_hsv_color_classifier.sv
`timescale 1ns / 1ps
// A start transfer passes the registers of max/min, hue numerator,
// nine divider stages and classification before its rsp_valid.
// Throughput: one pixel per clock; the nine-stage restoring divider is fully pipelined.
// busy is never raised and the receiver cannot stall, so nothing ever waits.
// Reset clears all valid bits and reloads the threshold registers with their defaults.
module rgb_to_hsv_color_classifier (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [rhcc_pkg::CompWidth-1:0]    req_blue,
   input  logic [rhcc_pkg::CompWidth-1:0]    req_green,
   input  logic [rhcc_pkg::CompWidth-1:0]    req_red,
   input  logic                              csr_we,
   input  logic [rhcc_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [rhcc_pkg::CsrWidth-1:0]     csr_wdata,
   output logic                              rsp_valid,
   output logic [rhcc_pkg::QuotWidth-1:0]    rsp_hue,
   output logic [rhcc_pkg::QuotWidth-1:0]    rsp_saturation_q8,
   output logic [rhcc_pkg::CompWidth-1:0]    rsp_value,
   output logic                              rsp_is_green_background,
   output logic                              rsp_is_green_font,
   output logic                              rsp_is_green,
   output logic                              rsp_is_white_background
);

   localparam int CW = rhcc_pkg::CompWidth;
   localparam int QW = rhcc_pkg::QuotWidth;
   localparam int NumWidth = 19;   // signed hue numerator before the wrap

   typedef enum logic [2:0] {
      CSR_SAT_THRESHOLD  = 3'd0,
      CSR_HUE_LOW        = 3'd1,
      CSR_HUE_HIGH       = 3'd2,
      CSR_DARK_VALUE_MAX = 3'd3,
      CSR_FONT_VALUE_MIN = 3'd4,
      CSR_WHITE_SAT      = 3'd5,
      CSR_WHITE_VALUE    = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      SECTOR_RED   = 2'd0,
      SECTOR_GREEN = 2'd1,
      SECTOR_BLUE  = 2'd2
   } sector_type;

   // configuration
   logic [QW-1:0] sat_threshold_ff;
   logic [QW-1:0] hue_low_ff;
   logic [QW-1:0] hue_high_ff;
   logic [CW-1:0] dark_value_max_ff;
   logic [CW-1:0] font_value_min_ff;
   logic [QW-1:0] white_sat_ff;
   logic [CW-1:0] white_value_min_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sat_threshold_ff   <= QW'(56);
         hue_low_ff         <= QW'(70);
         hue_high_ff        <= QW'(180);
         dark_value_max_ff  <= CW'(100);
         font_value_min_ff  <= CW'(150);
         white_sat_ff       <= QW'(50);
         white_value_min_ff <= CW'(140);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_SAT_THRESHOLD:  sat_threshold_ff   <= csr_wdata;
            CSR_HUE_LOW:        hue_low_ff         <= csr_wdata;
            CSR_HUE_HIGH:       hue_high_ff        <= csr_wdata;
            CSR_DARK_VALUE_MAX: dark_value_max_ff  <= csr_wdata[CW-1:0];
            CSR_FONT_VALUE_MIN: font_value_min_ff  <= csr_wdata[CW-1:0];
            CSR_WHITE_SAT:      white_sat_ff       <= csr_wdata;
            CSR_WHITE_VALUE:    white_value_min_ff <= csr_wdata[CW-1:0];
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage A: max, min and hue sector
   logic          accept;
   logic [CW-1:0] max_in;
   logic [CW-1:0] min_in;
   sector_type    sector_in;

   logic          a_valid_ff;
   logic [CW-1:0] a_blue_ff, a_green_ff, a_red_ff, a_max_ff, a_min_ff;
   sector_type    a_sector_ff;

   assign accept = start && !busy;

   always_comb begin
      max_in = req_red;
      if (req_green > max_in) max_in = req_green;
      if (req_blue > max_in)  max_in = req_blue;
      min_in = req_red;
      if (req_green < min_in) min_in = req_green;
      if (req_blue < min_in)  min_in = req_blue;
      // red wins ties, then green
      if (req_blue > req_green && req_blue > req_red) begin
         sector_in = SECTOR_BLUE;
      end else if (req_green > req_red) begin
         sector_in = SECTOR_GREEN;
      end else begin
         sector_in = SECTOR_RED;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= accept;
      end
      a_blue_ff   <= req_blue;
      a_green_ff  <= req_green;
      a_red_ff    <= req_red;
      a_max_ff    <= max_in;
      a_min_ff    <= min_in;
      a_sector_ff <= sector_in;
   end

   // stage B: hue numerator, exact: hue = num / delta with num in [0, 360*delta)
   logic [CW-1:0]              delta_in;
   logic signed [CW:0]         diff_in;
   logic signed [NumWidth-1:0] delta_ext;
   logic signed [NumWidth-1:0] num_in;
   rhcc_pkg::div_stage_type    b_div_ff;
   logic                       b_valid_ff;

   always_comb begin
      delta_in  = a_max_ff - a_min_ff;
      delta_ext = signed'(NumWidth'(delta_in));
      case (a_sector_ff)
         SECTOR_BLUE: begin
            diff_in = signed'({1'b0, a_red_ff}) - signed'({1'b0, a_green_ff});
            num_in  = NumWidth'(diff_in) * NumWidth'(60) + delta_ext * NumWidth'(240);
         end
         SECTOR_GREEN: begin
            diff_in = signed'({1'b0, a_blue_ff}) - signed'({1'b0, a_red_ff});
            num_in  = NumWidth'(diff_in) * NumWidth'(60) + delta_ext * NumWidth'(120);
         end
         default: begin
            diff_in = signed'({1'b0, a_green_ff}) - signed'({1'b0, a_blue_ff});
            num_in  = NumWidth'(diff_in) * NumWidth'(60);
            if (num_in < 0) begin
               num_in = num_in + delta_ext * NumWidth'(360);
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= a_valid_ff;
      end
      b_div_ff.hue_rem  <= num_in[rhcc_pkg::HueNumWidth-1:0];
      b_div_ff.hue_quot <= '0;
      b_div_ff.delta    <= delta_in;
      b_div_ff.sat_rem  <= {delta_in, 8'b0};
      b_div_ff.sat_quot <= '0;
      b_div_ff.max_val  <= a_max_ff;
   end

   // nine divider stages
   logic                    div_valid;
   rhcc_pkg::div_stage_type div_res;

   rhcc_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (b_valid_ff),
      .div_in    (b_div_ff),
      .out_valid (div_valid),
      .div_out   (div_res)
   );

   // classification; thresholds are integers so floor plus remainder gives exact tests
   logic sat_hi, sat_lo, white_lo, hue_in, green_in;
   logic bg_in, font_in, white_in;

   always_comb begin
      sat_hi = (div_res.sat_quot > sat_threshold_ff) ||
               ((div_res.sat_quot == sat_threshold_ff) && (div_res.sat_rem != '0));
      sat_lo   = (div_res.max_val != '0) && (div_res.sat_quot < sat_threshold_ff);
      white_lo = (div_res.max_val != '0) && (div_res.sat_quot < white_sat_ff);
      // gray pixel: delta is zero, and the hue test passes without checking the bounds
      hue_in = (div_res.delta == '0) ||
               ((div_res.hue_quot >= hue_low_ff) &&
                ((div_res.hue_quot < hue_high_ff) ||
                 ((div_res.hue_quot == hue_high_ff) && (div_res.hue_rem == '0))));
      green_in = sat_hi && hue_in;
      bg_in    = green_in || (sat_lo && (div_res.max_val < dark_value_max_ff));
      font_in  = sat_lo && (div_res.max_val > font_value_min_ff);
      white_in = white_lo && (div_res.max_val >= white_value_min_ff);
   end

   logic          rsp_valid_ff;
   logic [QW-1:0] rsp_hue_ff, rsp_sat_ff;
   logic [CW-1:0] rsp_value_ff;
   logic          rsp_bg_ff, rsp_font_ff, rsp_green_ff, rsp_white_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= div_valid;
      end
      rsp_hue_ff   <= div_res.hue_quot;
      rsp_sat_ff   <= div_res.sat_quot;
      rsp_value_ff <= div_res.max_val;
      rsp_bg_ff    <= bg_in;
      rsp_font_ff  <= font_in;
      rsp_green_ff <= green_in;
      rsp_white_ff <= white_in;
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_hue                 = rsp_hue_ff;
   assign rsp_saturation_q8       = rsp_sat_ff;
   assign rsp_value               = rsp_value_ff;
   assign rsp_is_green_background = rsp_bg_ff;
   assign rsp_is_green_font       = rsp_font_ff;
   assign rsp_is_green            = rsp_green_ff;
   assign rsp_is_white_background = rsp_white_ff;

endmodule
